### sv/stereo_envelope_mixer_assert.svh
`ifndef STEREO_ENVELOPE_MIXER_ASSERT_SVH
`define STEREO_ENVELOPE_MIXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SEM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stereo_envelope_mixer: port check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stereo_envelope_mixer: port check failed");

`endif

### sv/sem_pkg.sv
package sem_pkg;

  localparam int MOP_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 64;

  typedef logic [MOP_W-1:0] mop_t;

  // multiplier operations
  localparam mop_t MOP_NONE  = 4'd0;
  localparam mop_t MOP_L_END = 4'd1;
  localparam mop_t MOP_R_END = 4'd2;
  localparam mop_t MOP_L_AE  = 4'd3;
  localparam mop_t MOP_L_AS  = 4'd4;
  localparam mop_t MOP_R_AE  = 4'd5;
  localparam mop_t MOP_R_AS  = 4'd6;
  localparam mop_t MOP_G_MR  = 4'd7;
  localparam mop_t MOP_G_ML  = 4'd8;
  localparam mop_t MOP_G_AR  = 4'd9;
  localparam mop_t MOP_G_AL  = 4'd10;
  localparam mop_t MOP_M_MR  = 4'd11;
  localparam mop_t MOP_M_ML  = 4'd12;
  localparam mop_t MOP_M_AR  = 4'd13;
  localparam mop_t MOP_M_AL  = 4'd14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TGT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TGT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN    = 3'd7;

  localparam logic [31:0] Q15_ROUND = 32'h0000_4000;

  typedef struct packed {
    logic capture;
    logic grp;
    logic env;
    logic out_ld;
    mop_t mop;
  } cmd_t;

  typedef struct packed {
    logic in_first;
    logic in_init;
    logic gpos_zero;
    logic out_busy;
  } sts_t;

endpackage

### sv/sem_ctrl.sv
module sem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sem_pkg::sts_t sts,
  output sem_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT0 = 5'd1;
  localparam logic [4:0] S_INIT1 = 5'd2;
  localparam logic [4:0] S_INIT2 = 5'd3;
  localparam logic [4:0] S_GRP   = 5'd4;
  localparam logic [4:0] S_RMP0  = 5'd5;
  localparam logic [4:0] S_RMP1  = 5'd6;
  localparam logic [4:0] S_RMP2  = 5'd7;
  localparam logic [4:0] S_RMP3  = 5'd8;
  localparam logic [4:0] S_ENV   = 5'd9;
  localparam logic [4:0] S_G0    = 5'd10;
  localparam logic [4:0] S_G1    = 5'd11;
  localparam logic [4:0] S_G2    = 5'd12;
  localparam logic [4:0] S_G3    = 5'd13;
  localparam logic [4:0] S_M0    = 5'd14;
  localparam logic [4:0] S_M1    = 5'd15;
  localparam logic [4:0] S_M2    = 5'd16;
  localparam logic [4:0] S_M3    = 5'd17;
  localparam logic [4:0] S_LAST  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = (sts.in_first && sts.in_init) ? S_INIT0 : S_GRP;
        end
      end
      S_INIT0: begin
        cmd.mop   = sem_pkg::MOP_L_END;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        cmd.mop   = sem_pkg::MOP_R_END;
        state_nxt = S_INIT2;
      end
      S_INIT2: state_nxt = S_GRP;
      S_GRP: begin
        if (sts.gpos_zero) begin
          cmd.grp   = 1'b1;
          state_nxt = S_RMP0;
        end else begin
          state_nxt = S_ENV;
        end
      end
      S_RMP0: begin
        cmd.mop   = sem_pkg::MOP_L_AE;
        state_nxt = S_RMP1;
      end
      S_RMP1: begin
        cmd.mop   = sem_pkg::MOP_L_AS;
        state_nxt = S_RMP2;
      end
      S_RMP2: begin
        cmd.mop   = sem_pkg::MOP_R_AE;
        state_nxt = S_RMP3;
      end
      S_RMP3: begin
        cmd.mop   = sem_pkg::MOP_R_AS;
        state_nxt = S_ENV;
      end
      S_ENV: begin
        cmd.env   = 1'b1;
        state_nxt = S_G0;
      end
      S_G0: begin
        cmd.mop   = sem_pkg::MOP_G_MR;
        state_nxt = S_G1;
      end
      S_G1: begin
        cmd.mop   = sem_pkg::MOP_G_ML;
        state_nxt = S_G2;
      end
      S_G2: begin
        cmd.mop   = sem_pkg::MOP_G_AR;
        state_nxt = S_G3;
      end
      S_G3: begin
        cmd.mop   = sem_pkg::MOP_G_AL;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mop   = sem_pkg::MOP_M_MR;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mop   = sem_pkg::MOP_M_ML;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mop   = sem_pkg::MOP_M_AR;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.mop   = sem_pkg::MOP_M_AL;
        state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_OUT;
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/sem_datapath.sv
module sem_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sem_pkg::cmd_t                      cmd,
  output sem_pkg::sts_t                      sts,
  input  logic                               cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [sem_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [sem_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sem_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [15:0] lsv_r, rsv_r, ltgt_r, rtgt_r, wet_gain_r, dry_gain_r;
  logic [31:0] lrate_r, rrate_r;

  logic [15:0] wet_level_r, dry_level_r;
  logic [31:0] goal_left_r, goal_right_r, ramp_left_r, ramp_right_r;
  logic [31:0] as_left_r, ae_left_r, as_right_r, ae_right_r;
  logic [31:0] acc_left_r, acc_right_r, stp_left_r, stp_right_r;
  logic        upd_left_r, upd_right_r;
  logic [2:0]  gpos_r;

  logic [15:0] smp_r, mr_r, ml_r, ar_r, al_r;
  logic        aux_r;
  logic [15:0] lvl_left_r, lvl_right_r;
  logic [15:0] g_mr_r, g_ml_r, g_ar_r, g_al_r;
  logic [15:0] res_mr_r, res_ml_r, res_ar_r, res_al_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  sem_pkg::mop_t op_r;
  logic [31:0] rnd;
  logic [31:0] ramp_res;

  logic [31:0] acc_left_sum, acc_right_sum;
  logic        clamp_left, clamp_right;
  logic [31:0] acc_left_nxt, acc_right_nxt;

  logic        out_valid_r;
  logic [63:0] out_data_r;

  function automatic logic clamp_fn(input logic [31:0] sum, input logic [31:0] stp,
                                    input logic [31:0] goal);
    logic neg_or_zero;
    neg_or_zero = stp[31] || (stp == 32'd0);
    return (neg_or_zero && ($signed(sum) < $signed(goal))) ||
           (!neg_or_zero && ($signed(sum) > $signed(goal)));
  endfunction

  function automatic logic [15:0] mix_sat(input logic [15:0] bus, input logic [16:0] q);
    logic signed [17:0] sum;
    sum = $signed({{2{bus[15]}}, bus}) + $signed({q[16], q});
    if (sum > 18'sd32767) begin
      return 16'h7fff;
    end else if (sum < -18'sd32768) begin
      return 16'h8000;
    end
    return sum[15:0];
  endfunction

  assign sts.in_first  = in_tuser[0];
  assign sts.in_init   = in_tuser[1];
  assign sts.gpos_zero = (gpos_r == 3'd0);
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mop)
      sem_pkg::MOP_L_END: begin
        mul_a = {{16{lsv_r[15]}}, lsv_r};
        mul_b = lrate_r;
      end
      sem_pkg::MOP_R_END: begin
        mul_a = {{16{rsv_r[15]}}, rsv_r};
        mul_b = rrate_r;
      end
      sem_pkg::MOP_L_AE: begin
        mul_a = ae_left_r;
        mul_b = ramp_left_r;
      end
      sem_pkg::MOP_L_AS: begin
        mul_a = as_left_r;
        mul_b = ramp_left_r;
      end
      sem_pkg::MOP_R_AE: begin
        mul_a = ae_right_r;
        mul_b = ramp_right_r;
      end
      sem_pkg::MOP_R_AS: begin
        mul_a = as_right_r;
        mul_b = ramp_right_r;
      end
      sem_pkg::MOP_G_MR: begin
        mul_a = {{16{dry_level_r[15]}}, dry_level_r};
        mul_b = {{16{lvl_right_r[15]}}, lvl_right_r};
      end
      sem_pkg::MOP_G_ML: begin
        mul_a = {{16{dry_level_r[15]}}, dry_level_r};
        mul_b = {{16{lvl_left_r[15]}}, lvl_left_r};
      end
      sem_pkg::MOP_G_AR: begin
        mul_a = {{16{wet_level_r[15]}}, wet_level_r};
        mul_b = {{16{lvl_right_r[15]}}, lvl_right_r};
      end
      sem_pkg::MOP_G_AL: begin
        mul_a = {{16{wet_level_r[15]}}, wet_level_r};
        mul_b = {{16{lvl_left_r[15]}}, lvl_left_r};
      end
      sem_pkg::MOP_M_MR: begin
        mul_a = {{16{smp_r[15]}}, smp_r};
        mul_b = {{16{g_mr_r[15]}}, g_mr_r};
      end
      sem_pkg::MOP_M_ML: begin
        mul_a = {{16{smp_r[15]}}, smp_r};
        mul_b = {{16{g_ml_r[15]}}, g_ml_r};
      end
      sem_pkg::MOP_M_AR: begin
        mul_a = {{16{smp_r[15]}}, smp_r};
        mul_b = {{16{g_ar_r[15]}}, g_ar_r};
      end
      sem_pkg::MOP_M_AL: begin
        mul_a = {{16{smp_r[15]}}, smp_r};
        mul_b = {{16{g_al_r[15]}}, g_al_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd      = prod_r[31:0] + sem_pkg::Q15_ROUND;
  assign ramp_res = prod_r[47:16];

  assign acc_left_sum  = acc_left_r + stp_left_r;
  assign acc_right_sum = acc_right_r + stp_right_r;
  assign clamp_left    = clamp_fn(acc_left_sum, stp_left_r, goal_left_r);
  assign clamp_right   = clamp_fn(acc_right_sum, stp_right_r, goal_right_r);
  assign acc_left_nxt  = clamp_left ? goal_left_r : acc_left_sum;
  assign acc_right_nxt = clamp_right ? goal_right_r : acc_right_sum;

  always_ff @(posedge clk) begin
    prod_r <= $signed(mul_a) * $signed(mul_b);
    if (!rst_n) begin
      op_r <= sem_pkg::MOP_NONE;
    end else begin
      op_r <= cmd.mop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsv_r      <= '0;
      rsv_r      <= '0;
      lrate_r    <= '0;
      rrate_r    <= '0;
      ltgt_r     <= '0;
      rtgt_r     <= '0;
      wet_gain_r <= '0;
      dry_gain_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sem_pkg::CFG_LEFT_START:  lsv_r      <= cfg_wdata[15:0];
        sem_pkg::CFG_RIGHT_START: rsv_r      <= cfg_wdata[15:0];
        sem_pkg::CFG_LEFT_RATE:   lrate_r    <= cfg_wdata;
        sem_pkg::CFG_RIGHT_RATE:  rrate_r    <= cfg_wdata;
        sem_pkg::CFG_LEFT_TGT:    ltgt_r     <= cfg_wdata[15:0];
        sem_pkg::CFG_RIGHT_TGT:   rtgt_r     <= cfg_wdata[15:0];
        sem_pkg::CFG_WET_GAIN:    wet_gain_r <= cfg_wdata[15:0];
        sem_pkg::CFG_DRY_GAIN:    dry_gain_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r <= in_tdata[15:0];
      mr_r  <= in_tdata[31:16];
      ml_r  <= in_tdata[47:32];
      ar_r  <= in_tdata[63:48];
      al_r  <= in_tdata[79:64];
      aux_r <= in_tuser[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_level_r  <= '0;
      dry_level_r  <= '0;
      goal_left_r  <= '0;
      goal_right_r <= '0;
      ramp_left_r  <= '0;
      ramp_right_r <= '0;
      as_left_r    <= '0;
      ae_left_r    <= '0;
      as_right_r   <= '0;
      ae_right_r   <= '0;
      acc_left_r   <= '0;
      acc_right_r  <= '0;
      stp_left_r   <= '0;
      stp_right_r  <= '0;
      upd_left_r   <= 1'b0;
      upd_right_r  <= 1'b0;
      gpos_r       <= '0;
      lvl_left_r   <= '0;
      lvl_right_r  <= '0;
    end else begin
      if (cmd.capture && in_tuser[0]) begin
        gpos_r <= '0;
        if (in_tuser[1]) begin
          wet_level_r  <= wet_gain_r;
          dry_level_r  <= dry_gain_r;
          goal_left_r  <= {ltgt_r, 16'h0000};
          goal_right_r <= {rtgt_r, 16'h0000};
          as_left_r    <= {lsv_r, 16'h0000};
          as_right_r   <= {rsv_r, 16'h0000};
          ramp_left_r  <= lrate_r;
          ramp_right_r <= rrate_r;
        end
      end

      if (cmd.grp) begin
        upd_left_r  <= (as_left_r != goal_left_r);
        upd_right_r <= (as_right_r != goal_right_r);
        if (as_left_r != goal_left_r) begin
          stp_left_r <= $unsigned($signed(ae_left_r - as_left_r) >>> 3);
          acc_left_r <= as_left_r;
        end else begin
          stp_left_r <= '0;
          acc_left_r <= goal_left_r;
        end
        if (as_right_r != goal_right_r) begin
          stp_right_r <= $unsigned($signed(ae_right_r - as_right_r) >>> 3);
          acc_right_r <= as_right_r;
        end else begin
          stp_right_r <= '0;
          acc_right_r <= goal_right_r;
        end
      end

      // clamp to goal takes priority over a ramp write-back in the same cycle
      unique case (op_r)
        sem_pkg::MOP_L_END: ae_left_r  <= prod_r[31:0];
        sem_pkg::MOP_R_END: ae_right_r <= prod_r[31:0];
        sem_pkg::MOP_L_AE: if (upd_left_r) ae_left_r <= ramp_res;
        sem_pkg::MOP_L_AS: if (upd_left_r) as_left_r <= ramp_res;
        sem_pkg::MOP_R_AE: if (upd_right_r) ae_right_r <= ramp_res;
        sem_pkg::MOP_R_AS: if (upd_right_r && !(cmd.env && clamp_right)) as_right_r <= ramp_res;
        default: ;
      endcase

      if (cmd.env) begin
        acc_left_r  <= acc_left_nxt;
        acc_right_r <= acc_right_nxt;
        lvl_left_r  <= acc_left_nxt[31:16];
        lvl_right_r <= acc_right_nxt[31:16];
        gpos_r      <= gpos_r + 3'd1;
        if (clamp_left) begin
          as_left_r <= goal_left_r;
        end
        if (clamp_right) begin
          as_right_r <= goal_right_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op_r)
      sem_pkg::MOP_G_MR: g_mr_r <= rnd[30:15];
      sem_pkg::MOP_G_ML: g_ml_r <= rnd[30:15];
      sem_pkg::MOP_G_AR: g_ar_r <= rnd[30:15];
      sem_pkg::MOP_G_AL: g_al_r <= rnd[30:15];
      sem_pkg::MOP_M_MR: res_mr_r <= mix_sat(mr_r, rnd[31:15]);
      sem_pkg::MOP_M_ML: res_ml_r <= mix_sat(ml_r, rnd[31:15]);
      sem_pkg::MOP_M_AR: res_ar_r <= aux_r ? mix_sat(ar_r, rnd[31:15]) : ar_r;
      sem_pkg::MOP_M_AL: res_al_r <= aux_r ? mix_sat(al_r, rnd[31:15]) : al_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {res_al_r, res_ar_r, res_ml_r, res_mr_r};
    end
  end

endmodule

### sv/stereo_envelope_mixer.sv
// channel  | group                          | role
// in_      | tvalid/tready/tdata/tuser      | sample and four bus values
// out_     | tvalid/tready/tdata            | four mixed bus values
// cfg_     | we/index/wdata                 | envelope and gain registers
//
// A transaction runs longer at the start of each eight-sample group and with an
// envelope init; a single shared 32x32 multiplier does all products.
// rst_n is synchronous, active low, and clears the envelope and config registers.
// A result waits in the output register while the next transaction is taken.
// With the output register still full, the block holds before its last step.
module stereo_envelope_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // sample_in, main_right_in, main_left_in, aux_right_in, aux_left_in
  input  logic [sem_pkg::IN_DATA_W-1:0]      in_tdata,
  // first_of_command, init_envelope, aux_enable
  input  logic [sem_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // main_right_out, main_left_out, aux_right_out, aux_left_out
  output logic [sem_pkg::OUT_DATA_W-1:0]     out_tdata
);

  sem_pkg::cmd_t cmd;
  sem_pkg::sts_t sts;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sem_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sv/sem_checker.sv
`include "stereo_envelope_mixer_assert.svh"

module sem_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sem_pkg::OUT_DATA_W-1:0]     out_tdata
);

  `SEM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SEM_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `SEM_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready, !$rose(out_tvalid))
  `SEM_ASSERT_SAME(a_idle_on_result, $rose(out_tvalid), in_tready)

endmodule

bind stereo_envelope_mixer sem_checker u_sem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sem_pkg::*;

  localparam int SIDE_L = 0;
  localparam int SIDE_R = 1;
  localparam int USER_FIRST = 0;
  localparam int USER_INIT = 1;
  localparam int USER_AUX = 2;
  localparam int NUM_REGS = 1 << CFG_IDX_W;
  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // register shadow and the values for the next load
  logic [31:0] cfg_shadow [NUM_REGS];
  logic [31:0] next_cfg [NUM_REGS];

  // envelope state, one entry per side
  logic [31:0] env_goal [2];
  logic [31:0] env_ramp [2];
  logic [31:0] adder_start [2];
  logic [31:0] adder_end [2];
  logic [31:0] env_accum [2];
  logic [31:0] env_step [2];
  logic [15:0] wet_level;
  logic [15:0] dry_level;
  logic [2:0] group_pos;

  logic [OUT_DATA_W-1:0] bus_expect_q [$];
  logic [OUT_DATA_W-1:0] want_buses;
  string bus_name [4] = '{"main_right", "main_left", "aux_right", "aux_left"};

  int mismatches = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  stereo_envelope_mixer u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want_buses = bus_expect_q.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (want_buses[16*f +: 16] !== out_tdata[16*f +: 16]) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, bus_name[f],
                     want_buses[16*f +: 16], out_tdata[16*f +: 16]);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic int sx16(input logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int q15(input int a, input int b);
    longint p;
    p = longint'(a) * longint'(b) + longint'(Q15_ROUND);
    return int'(p >>> 15);
  endfunction

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [31:0] ramp_mul(input logic [31:0] a, input logic [31:0] r);
    longint p;
    p = longint'($signed(a)) * longint'($signed(r));
    return p[47:16];
  endfunction

  function automatic void load_side(input int s, input int start_idx, input int rate_idx,
                                    input int tgt_idx);
    longint p;
    p = longint'(sx16(cfg_shadow[start_idx][15:0])) * longint'($signed(cfg_shadow[rate_idx]));
    env_goal[s] = {cfg_shadow[tgt_idx][15:0], 16'h0000};
    adder_start[s] = {cfg_shadow[start_idx][15:0], 16'h0000};
    adder_end[s] = p[31:0];
    env_ramp[s] = cfg_shadow[rate_idx];
  endfunction

  function automatic void group_start(input int s);
    logic signed [31:0] diff;
    if (adder_start[s] != env_goal[s]) begin
      diff = adder_end[s] - adder_start[s];
      env_step[s] = diff >>> 3;
      env_accum[s] = adder_start[s];
      adder_end[s] = ramp_mul(adder_end[s], env_ramp[s]);
      adder_start[s] = ramp_mul(env_accum[s], env_ramp[s]);
    end else begin
      env_accum[s] = env_goal[s];
      env_step[s] = '0;
    end
  endfunction

  function automatic int env_advance(input int s);
    logic signed [31:0] st;
    logic signed [31:0] acc;
    logic signed [31:0] goal;
    env_accum[s] = env_accum[s] + env_step[s];
    st = env_step[s];
    acc = env_accum[s];
    goal = env_goal[s];
    if ((st <= 0 && acc < goal) || (st > 0 && acc > goal)) begin
      env_accum[s] = env_goal[s];
      adder_start[s] = env_goal[s];
    end
    return sx16(env_accum[s][31:16]);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_buses(input logic [IN_DATA_W-1:0] d,
                                                          input logic [IN_USER_W-1:0] u);
    int smp, mr, ml, ar, al, lvl, rvl, dry, wet;
    smp = sx16(d[15:0]);
    mr = sx16(d[31:16]);
    ml = sx16(d[47:32]);
    ar = sx16(d[63:48]);
    al = sx16(d[79:64]);
    if (u[USER_FIRST]) begin
      group_pos = '0;
      if (u[USER_INIT]) begin
        wet_level = cfg_shadow[CFG_WET_GAIN][15:0];
        dry_level = cfg_shadow[CFG_DRY_GAIN][15:0];
        load_side(SIDE_L, CFG_LEFT_START, CFG_LEFT_RATE, CFG_LEFT_TGT);
        load_side(SIDE_R, CFG_RIGHT_START, CFG_RIGHT_RATE, CFG_RIGHT_TGT);
      end
    end
    if (group_pos == 3'd0) begin
      group_start(SIDE_L);
      group_start(SIDE_R);
    end
    lvl = env_advance(SIDE_L);
    rvl = env_advance(SIDE_R);
    dry = sx16(dry_level);
    wet = sx16(wet_level);
    mr = sat16(mr + q15(smp, sx16(16'(q15(dry, rvl)))));
    ml = sat16(ml + q15(smp, sx16(16'(q15(dry, lvl)))));
    if (u[USER_AUX]) begin
      ar = sat16(ar + q15(smp, sx16(16'(q15(wet, rvl)))));
      al = sat16(al + q15(smp, sx16(16'(q15(wet, lvl)))));
    end
    group_pos = group_pos + 3'd1;
    return {al[15:0], ar[15:0], ml[15:0], mr[15:0]};
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_buses(input logic [15:0] smp,
                                                      input logic [15:0] mr,
                                                      input logic [15:0] ml,
                                                      input logic [15:0] ar,
                                                      input logic [15:0] al);
    return {al, ar, ml, mr, smp};
  endfunction

  function automatic logic [IN_USER_W-1:0] user_bits(input bit first, input bit init,
                                                     input bit aux);
    logic [IN_USER_W-1:0] u;
    u = '0;
    u[USER_FIRST] = first;
    u[USER_INIT] = init;
    u[USER_AUX] = aux;
    return u;
  endfunction

  function automatic logic [15:0] extreme_word(input int k);
    case (k % 4)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 511));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4, 5: return $urandom;
      default: return 32'h0001_0000 + 32'($urandom_range(0, 32'h4000)) - 32'h2000;
    endcase
  endfunction

  task automatic load_registers();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_wdata <= next_cfg[i];
      if (i == int'(CFG_LEFT_RATE) || i == int'(CFG_RIGHT_RATE))
        cfg_shadow[i] = next_cfg[i];
      else
        cfg_shadow[i] = {16'h0000, next_cfg[i][15:0]};
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic [IN_DATA_W-1:0] d, input logic [IN_USER_W-1:0] u);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= u;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bus_expect_q.push_back(predict_buses(d, u));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (bus_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mix from the zero reset state, with stray init and a command without init
  task automatic test_unconfigured();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(pack_buses(16'h7FFF, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF),
                user_bits(1'b0, 1'b0, 1'b1));
    send_sample(pack_buses(16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h0000),
                user_bits(1'b1, 1'b0, 1'b1));
    send_sample(pack_buses(16'h4321, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000),
                user_bits(1'b0, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_directed_extremes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    next_cfg[CFG_LEFT_START] = 32'h0000_7FFF;
    next_cfg[CFG_RIGHT_START] = 32'hFFFF_8000;
    next_cfg[CFG_LEFT_RATE] = 32'h7FFF_FFFF;
    next_cfg[CFG_RIGHT_RATE] = 32'h8000_0000;
    next_cfg[CFG_LEFT_TGT] = 32'h0000_8000;
    next_cfg[CFG_RIGHT_TGT] = 32'h0000_7FFF;
    next_cfg[CFG_WET_GAIN] = 32'h0000_8000;
    next_cfg[CFG_DRY_GAIN] = 32'h0000_7FFF;
    load_registers();
    for (int i = 0; i < 10; i++) begin
      send_sample(pack_buses(extreme_word(i), extreme_word(i + 1), extreme_word(i + 2),
                             extreme_word(i + 3), extreme_word(i)),
                  user_bits(i == 0, i == 0, i[0]));
    end
    wait_idle();

    next_cfg[CFG_LEFT_START] = 32'h0000_0100;
    next_cfg[CFG_RIGHT_START] = 32'h0000_8000;
    next_cfg[CFG_LEFT_RATE] = 32'h0001_8000;
    next_cfg[CFG_RIGHT_RATE] = 32'h8000_0000;
    next_cfg[CFG_LEFT_TGT] = 32'h0000_7FFF;
    next_cfg[CFG_RIGHT_TGT] = 32'h0000_8000;
    next_cfg[CFG_WET_GAIN] = 32'h0000_7FFF;
    next_cfg[CFG_DRY_GAIN] = 32'h0000_8000;
    load_registers();
    send_sample(pack_buses(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF),
                user_bits(1'b0, 1'b1, 1'b1));
    send_sample(pack_buses(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000),
                user_bits(1'b1, 1'b0, 1'b1));
    for (int i = 0; i < 10; i++) begin
      send_sample(pack_buses(extreme_word(i + 1), extreme_word(i), extreme_word(i + 3),
                             extreme_word(i + 2), extreme_word(i + 1)),
                  user_bits(i == 0, i == 0, !i[0]));
    end
    wait_idle();
  endtask

  task automatic random_config();
    for (int i = 0; i < NUM_REGS; i++) next_cfg[i] = {16'($urandom), rand_word()};
    next_cfg[CFG_LEFT_RATE] = rand_rate();
    next_cfg[CFG_RIGHT_RATE] = rand_rate();
    if ($urandom_range(0, 3) == 0)
      next_cfg[CFG_LEFT_TGT][15:0] = next_cfg[CFG_LEFT_START][15:0];
    if ($urandom_range(0, 3) == 0)
      next_cfg[CFG_RIGHT_TGT][15:0] = next_cfg[CFG_RIGHT_START][15:0];
  endtask

  // mix commands with random content, some noise, and a new setting per half
  task automatic test_ramp_stream(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int len;
    bit noise;
    logic [IN_USER_W-1:0] u;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      random_config();
      load_registers();
      sent = 0;
      while (sent < n_items / 2) begin
        len = $urandom_range(1, 40);
        noise = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len && sent < n_items / 2; k++) begin
          if (noise)
            u = IN_USER_W'($urandom);
          else
            u = user_bits(k == 0,
                          (k == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 19) == 0),
                          1'($urandom));
          send_sample(pack_buses(rand_word(), rand_word(), rand_word(), rand_word(),
                                 rand_word()), u);
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_shadow[i] = '0;
      next_cfg[i] = '0;
    end
    for (int s = 0; s < 2; s++) begin
      env_goal[s] = '0;
      env_ramp[s] = '0;
      adder_start[s] = '0;
      adder_end[s] = '0;
      env_accum[s] = '0;
      env_step[s] = '0;
    end
    wet_level = '0;
    dry_level = '0;
    group_pos = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unconfigured();
    test_directed_extremes();
    test_ramp_stream(0, 0, 176);
    test_ramp_stream(63, 0, 176);
    test_ramp_stream(0, 63, 176);
    test_ramp_stream(20, 20, 176);

    repeat (30) @(posedge clk);
    if (mismatches == 0 && bus_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
